FILE: rtl/pktb_pkg.sv
// pktb_pkg: shared types and constants for the per-key token bucket limiter
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package pktb_pkg;

  // defaults for the top-level parameters
  localparam int NUM_KEYS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  // field widths
  localparam int OP_W      = 2;
  localparam int KEY_FLD_W = 6;
  localparam int TIME_W    = 32;
  localparam int TOKEN_W   = 32;
  localparam int CAP_W     = 16;
  localparam int RATE_W    = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;

  // shared unit width: level plus elapsed times rate, one bit of carry
  localparam int ALU_W = TIME_W + RATE_W + 1;

  // operation codes of an input word
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 1'b1;

  // shared unit operations
  localparam logic [1:0] ALU_MUL = 2'd0;
  localparam logic [1:0] ALU_ADD = 2'd1;
  localparam logic [1:0] ALU_MIN = 2'd2;
  localparam logic [1:0] ALU_SUB = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               live;
    logic [TOKEN_W-1:0] level;
    logic [TIME_W-1:0]  last;
  } tbl_entry_t;

endpackage

FILE: rtl/pktb_if.sv
// pktb_if: valid/ready channel interfaces for input and result words
// depends on pktb_pkg for field widths
`timescale 1ns / 1ps

interface pktb_in_if;
  import pktb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [KEY_FLD_W-1:0] flow_key;
  logic [TIME_W-1:0]    now_time;

  modport source (output valid, output operation, output flow_key, output now_time,
                  input ready);
  modport sink (input valid, input operation, input flow_key, input now_time,
                output ready);
endinterface

interface pktb_out_if;
  import pktb_pkg::*;
  logic               valid;
  logic               ready;
  logic               allowed;
  logic [TOKEN_W-1:0] remaining_tokens;

  modport source (output valid, output allowed, output remaining_tokens, input ready);
  modport sink (input valid, input allowed, input remaining_tokens, output ready);
endinterface

FILE: rtl/per_key_token_bucket_limiter_top.sv
// per_key_token_bucket_limiter_top: sequencer, config registers and output register
// depends on pktb_pkg, pktb_if, pktb_alu and pktb_table
`timescale 1ns / 1ps

// Per-key token bucket limiter.
// in_ch carries one word per operation: request a token, query the level or
// reset a key, with the flow key and the current tick count. out_ch returns one
// word per input: allowed and the remaining tokens in Q16.16 (FRAC_BITS frac).
// Configuration is written through cfg_we / cfg_index / cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// Request and query go from accept through one table read, then multiply,
// add, saturate and subtract steps through the single shared arithmetic unit,
// then a table write-back that loads the result; only then is the next input
// accepted. Reset, unused operations and out-of-range keys go straight from
// accept to the write-back. The result word is registered and is valid in the
// cycle after the write-back. After rst_n the table is swept clear, one entry
// a cycle, through all NUM_KEYS entries; in_ch.ready stays low during the sweep.
// The result sits in an output register; if the receiver stalls, the block
// holds its finished word and does not write back or accept until it is taken.

module per_key_token_bucket_limiter_top #(
  parameter int NUM_KEYS  = pktb_pkg::NUM_KEYS_DEF,
  parameter int FRAC_BITS = pktb_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pktb_in_if.sink                          in_ch,
  pktb_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [pktb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pktb_pkg::CFG_W-1:0]       cfg_wdata
);
  import pktb_pkg::*;

  localparam int KEY_W     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CAP_FULL_W = CAP_W + FRAC_BITS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;
  localparam logic [2:0] ST_SUB   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [ALU_W-1:0] ONE_TOK = ALU_W'(1) << FRAC_BITS;

  logic [2:0]         state_r, state_nxt;
  logic [KEY_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic               req_r, req_nxt;
  logic               refill_r, refill_nxt;
  logic               drop_r, drop_nxt;
  logic [TOKEN_W-1:0] level_r, level_nxt;

  logic [CAP_W-1:0]   cap_r;
  logic [RATE_W-1:0]  rate_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_allowed_r, out_allowed_nxt;
  logic [TOKEN_W-1:0] out_rem_r, out_rem_nxt;

  logic               in_fire;
  logic               done_fire;
  logic               key_ok;
  logic [CAP_FULL_W-1:0] cap_full;
  logic [TOKEN_W-1:0] cap_tok;
  logic [TOKEN_W-1:0] level_v;
  logic [TIME_W-1:0]  last_v;
  logic               take;
  logic [TOKEN_W-1:0] new_level;

  alu_req_t           alu_req;
  logic [ALU_W-1:0]   alu_res;
  logic               alu_flag;

  logic               tbl_wr_en;
  logic [KEY_W-1:0]   tbl_wr_addr;
  tbl_entry_t         tbl_wr_data;
  tbl_entry_t         tbl_rd_data;

  pktb_alu u_alu (
    .clk  (clk),
    .req  (alu_req),
    .res  (alu_res),
    .flag (alu_flag)
  );

  pktb_table #(.NUM_KEYS(NUM_KEYS)) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (in_fire),
    .rd_addr (KEY_W'(in_ch.flow_key)),
    .rd_data (tbl_rd_data)
  );

  // capacity in token format, saturated to 32 bits
  assign cap_full = CAP_FULL_W'(cap_r) << FRAC_BITS;
  assign cap_tok  = ((cap_full >> TOKEN_W) != '0) ? '1 : TOKEN_W'(cap_full);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign done_fire   = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign key_ok      = (32'(in_ch.flow_key) < 32'(NUM_KEYS));

  // a bucket that is not live starts full with zero elapsed time
  assign level_v = tbl_rd_data.live ? tbl_rd_data.level : cap_tok;
  assign last_v  = tbl_rd_data.live ? tbl_rd_data.last : now_r;

  assign take      = req_r && alu_flag;
  assign new_level = take ? alu_res[TOKEN_W-1:0] : level_r;

  always_comb begin
    alu_req.op = ALU_MUL;
    alu_req.a  = ALU_W'(now_r - last_v);
    alu_req.b  = ALU_W'(rate_r);
    case (state_r)
      ST_ADD: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'(level_r);
        alu_req.b  = alu_res;
      end
      ST_SAT: begin
        alu_req.op = ALU_MIN;
        alu_req.a  = alu_res;
        alu_req.b  = ALU_W'(cap_tok);
      end
      ST_SUB: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = alu_res;
        alu_req.b  = ONE_TOK;
      end
      ST_DONE: begin
        // keep the take decision steady while the result register is full
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(level_r);
        alu_req.b  = ONE_TOK;
      end
      default: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = ALU_W'(now_r - last_v);
        alu_req.b  = ALU_W'(rate_r);
      end
    endcase
  end

  always_comb begin
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = key_r;
    tbl_wr_data = '0;
    if (state_r == ST_CLEAR) begin
      tbl_wr_en   = 1'b1;
      tbl_wr_addr = clr_cnt_r;
    end else if (done_fire && (refill_r || drop_r)) begin
      tbl_wr_en         = 1'b1;
      tbl_wr_data.live  = refill_r;
      tbl_wr_data.level = new_level;
      tbl_wr_data.last  = now_r;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    key_nxt         = key_r;
    now_nxt         = now_r;
    req_nxt         = req_r;
    refill_nxt      = refill_r;
    drop_nxt        = drop_r;
    level_nxt       = level_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_allowed_nxt = out_allowed_r;
    out_rem_nxt     = out_rem_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == KEY_W'(NUM_KEYS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          key_nxt    = KEY_W'(in_ch.flow_key);
          now_nxt    = in_ch.now_time;
          req_nxt    = (in_ch.operation == OP_REQUEST);
          refill_nxt = key_ok && ((in_ch.operation == OP_REQUEST) ||
                                  (in_ch.operation == OP_QUERY));
          drop_nxt   = key_ok && (in_ch.operation == OP_RESET);
          state_nxt  = (key_ok && ((in_ch.operation == OP_REQUEST) ||
                                   (in_ch.operation == OP_QUERY))) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        level_nxt = level_v;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        // saturated level, kept for a query or a refused request
        level_nxt = alu_res[TOKEN_W-1:0];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (done_fire) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = refill_r && take;
          out_rem_nxt     = refill_r ? new_level : '0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    now_r         <= now_nxt;
    req_r         <= req_nxt;
    refill_r      <= refill_nxt;
    drop_r        <= drop_nxt;
    level_r       <= level_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_rem_r     <= out_rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_W'(16);
      rate_r <= RATE_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY: cap_r  <= cfg_wdata[CAP_W-1:0];
        CFG_RATE:     rate_r <= cfg_wdata[RATE_W-1:0];
        default: begin
          cap_r <= cap_r;
        end
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.allowed          = out_allowed_r;
  assign out_ch.remaining_tokens = out_rem_r;

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result word raised outside the write-back step");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ch.ready)
    else $error("input accepted during table sweep");

  a_table_write_site: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr_en |-> ((state_r == ST_CLEAR) || done_fire))
    else $error("table written outside sweep or write-back");

  a_done_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_valid_r && !out_ch.ready) |=> (state_r == ST_DONE))
    else $error("write-back left while result register was full");
`endif

endmodule

FILE: rtl/pktb_alu.sv
// pktb_alu: shared multiply / add / min / subtract unit with registered result
// depends on pktb_pkg for the request struct and operation codes
`timescale 1ns / 1ps

module pktb_alu (
  input  logic                   clk,
  input  pktb_pkg::alu_req_t     req,
  output logic [pktb_pkg::ALU_W-1:0] res,
  output logic                   flag
);
  import pktb_pkg::*;

  logic [ALU_W-1:0] res_r, res_nxt;
  logic             flag_r, flag_nxt;

  always_comb begin
    res_nxt  = req.a;
    flag_nxt = 1'b0;
    case (req.op)
      ALU_MUL: begin
        res_nxt = ALU_W'(req.a[TIME_W-1:0]) * ALU_W'(req.b[RATE_W-1:0]);
      end
      ALU_ADD: begin
        res_nxt = req.a + req.b;
      end
      ALU_MIN: begin
        // flag set when a is the smaller
        flag_nxt = (req.a < req.b);
        res_nxt  = flag_nxt ? req.a : req.b;
      end
      ALU_SUB: begin
        // flag set when there is no borrow
        flag_nxt = (req.a >= req.b);
        res_nxt  = req.a - req.b;
      end
      default: begin
        res_nxt  = req.a;
        flag_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    flag_r <= flag_nxt;
  end

  assign res  = res_r;
  assign flag = flag_r;

endmodule

FILE: rtl/pktb_table.sv
// pktb_table: bucket table memory, one write and one registered read port
// depends on pktb_pkg for the entry struct
`timescale 1ns / 1ps

module pktb_table #(
  parameter int NUM_KEYS = pktb_pkg::NUM_KEYS_DEF,
  localparam int KEY_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [KEY_W-1:0]     wr_addr,
  input  pktb_pkg::tbl_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [KEY_W-1:0]     rd_addr,
  output pktb_pkg::tbl_entry_t rd_data
);
  import pktb_pkg::*;

  tbl_entry_t mem [NUM_KEYS];
  tbl_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
